/* rtl/csa_pkg.sv */
// csa_pkg: shared types and codes of the context slot allocator
// used by csa_desc_check and context_slot_allocator, no dependencies
package csa_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int OWNER_W  = 16;
    localparam int DIM_W    = 16;
    localparam int BUF_W    = 8;
    localparam int FLAG_W   = 8;
    localparam int RSV_W    = 16;
    localparam int SLOT_W   = 4;
    localparam int QUOTA_W  = 5;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_STATE   = 2'd3;

    // request kinds
    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWNER_QUOTA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFERS_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFERS_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_MASK    = 3'd5;

    typedef struct packed {
        logic [QUOTA_W-1:0] owner_quota;
        logic [DIM_W-1:0]   width_limit;
        logic [DIM_W-1:0]   height_limit;
        logic [BUF_W-1:0]   buffers_min;
        logic [BUF_W-1:0]   buffers_max;
        logic [FLAG_W-1:0]  flag_mask;
    } cfg_t;

endpackage

/* rtl/context_slot_allocator.sv */
// context_slot_allocator: free list / active list slot pool with per-owner quota
// depends on csa_pkg, csa_ram, csa_desc_check
//
//  channel   dir  handshake          payload
//  s_        in   tvalid/tready      tdata: descriptor and slot, tuser: req_type
//  m_        out  tvalid/tready      tdata: status, slot_out
//  cfg_      in   cfg_wr_en          cfg_index, cfg_data
//
// one request at a time: allocate passes the check, the owner count walk over the
// active list (at most SLOTS entries), the free pop and two write states; release passes
// the check, an evaluate state and a second write state; a bad descriptor, zero owner or
// zero quota answers from the check, release of a free slot from evaluate, a quota stop
// from the walk, an empty free list from the free pop; the walk reads one entry per cycle
// after reset a clearing pass over all SLOTS entries rebuilds the free chain, no
// transfer is accepted meanwhile; a held result does not stop the next accept,
// the next result waits in the response state until the output register frees
module context_slot_allocator
    import csa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // owner[15:0] width[31:16] height[47:32] buf_cnt[55:48] flags[63:56]
    // reserved_bytes[79:64] slot[83:80] zeros[87:84]
    input  logic [87:0]           s_tdata,
    // req_type[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[1:0] slot_out[5:2] zeros[7:6]
    output logic [7:0]            m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = $clog2(SLOTS + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [LW-1:0] LINK_NONE = LW'(SLOTS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_FREE,
        S_ALLOC_WR1,
        S_ALLOC_WR2,
        S_REL_EVAL,
        S_REL_WR2,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    cfg_t cfg_reg;

    // request registers
    logic              req_type_reg;
    logic [OWNER_W-1:0] req_owner_reg;
    logic [DIM_W-1:0]  req_width_reg;
    logic [DIM_W-1:0]  req_height_reg;
    logic [BUF_W-1:0]  req_buf_reg;
    logic [FLAG_W-1:0] req_flags_reg;
    logic [RSV_W-1:0]  req_rsv_reg;
    logic [SLOT_W-1:0] req_slot_reg;

    logic [LW-1:0]      free_head_reg, free_head_next;
    logic [LW-1:0]      active_head_reg, active_head_next;
    logic [LW-1:0]      clr_idx_reg, clr_idx_next;
    logic [LW-1:0]      steps_reg, steps_next;
    logic [QUOTA_W-1:0] count_reg, count_next;
    logic [AW-1:0]      work_idx_reg, work_idx_next;
    logic [STATUS_W-1:0] resp_status_reg, resp_status_next;
    logic [SLOT_W-1:0]  resp_slot_reg, resp_slot_next;
    logic               m_tvalid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]  out_slot_reg;

    // ram ports
    logic [AW-1:0]      rd_addr;
    logic [LW-1:0]      next_rd, prev_rd;
    logic [OWNER_W-1:0] owner_rd;
    logic               used_rd;
    logic               next_we, prev_we, owner_we, used_we;
    logic [AW-1:0]      next_waddr, prev_waddr, owner_waddr, used_waddr;
    logic [LW-1:0]      next_wdata, prev_wdata;
    logic [OWNER_W-1:0] owner_wdata;
    logic               used_wdata;

    logic               desc_ok;
    logic [LW+3:0]      slot_wide;
    logic               slot_valid;
    logic [AW-1:0]      slot_idx;
    logic [AW+3:0]      work_wide;
    logic [SLOT_W-1:0]  work_slot4;
    logic               owner_hit;
    logic [QUOTA_W-1:0] count_new;
    logic [LW-1:0]      steps_new;
    logic               out_free;

    assign slot_wide  = {{LW{1'b0}}, req_slot_reg};
    assign slot_valid = slot_wide < (LW + 4)'(SLOTS);
    assign slot_idx   = slot_wide[AW-1:0];
    assign work_wide  = {4'b0000, work_idx_reg};
    assign work_slot4 = work_wide[SLOT_W-1:0];

    assign owner_hit = (owner_rd == req_owner_reg);
    assign count_new = count_reg + QUOTA_W'(owner_hit);
    assign steps_new = steps_reg + LW'(1);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_slot_reg, out_status_reg};

    csa_desc_check u_desc (
        .cfg            (cfg_reg),
        .width          (req_width_reg),
        .height         (req_height_reg),
        .buf_cnt        (req_buf_reg),
        .flags          (req_flags_reg),
        .reserved_bytes (req_rsv_reg),
        .desc_ok        (desc_ok)
    );

    csa_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next_mem (
        .aclk (aclk), .we (next_we), .waddr (next_waddr), .wdata (next_wdata),
        .raddr (rd_addr), .rdata (next_rd)
    );

    csa_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_prev_mem (
        .aclk (aclk), .we (prev_we), .waddr (prev_waddr), .wdata (prev_wdata),
        .raddr (rd_addr), .rdata (prev_rd)
    );

    csa_ram #(.WIDTH(OWNER_W), .DEPTH(SLOTS)) u_owner_mem (
        .aclk (aclk), .we (owner_we), .waddr (owner_waddr), .wdata (owner_wdata),
        .raddr (rd_addr), .rdata (owner_rd)
    );

    csa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_used_mem (
        .aclk (aclk), .we (used_we), .waddr (used_waddr), .wdata (used_wdata),
        .raddr (rd_addr), .rdata (used_rd)
    );

    // sequencer
    always_comb begin
        state_next       = state_reg;
        free_head_next   = free_head_reg;
        active_head_next = active_head_reg;
        clr_idx_next     = clr_idx_reg;
        steps_next       = steps_reg;
        count_next       = count_reg;
        work_idx_next    = work_idx_reg;
        resp_status_next = resp_status_reg;
        resp_slot_next   = resp_slot_reg;

        rd_addr     = '0;
        next_we     = 1'b0;
        prev_we     = 1'b0;
        owner_we    = 1'b0;
        used_we     = 1'b0;
        next_waddr  = work_idx_reg;
        prev_waddr  = work_idx_reg;
        owner_waddr = work_idx_reg;
        used_waddr  = work_idx_reg;
        next_wdata  = LINK_NONE;
        prev_wdata  = LINK_NONE;
        owner_wdata = '0;
        used_wdata  = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                // chain slot i to i+1, last one to none
                next_we     = 1'b1;
                prev_we     = 1'b1;
                owner_we    = 1'b1;
                used_we     = 1'b1;
                next_waddr  = clr_idx_reg[AW-1:0];
                prev_waddr  = clr_idx_reg[AW-1:0];
                owner_waddr = clr_idx_reg[AW-1:0];
                used_waddr  = clr_idx_reg[AW-1:0];
                next_wdata  = clr_idx_reg + LW'(1);
                clr_idx_next = clr_idx_reg + LW'(1);
                if (clr_idx_reg == LW'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                resp_slot_next = '0;
                count_next     = '0;
                steps_next     = '0;
                if (req_type_reg == REQ_RELEASE) begin
                    rd_addr        = slot_idx;
                    work_idx_next  = slot_idx;
                    resp_slot_next = req_slot_reg;
                    if (!slot_valid) begin
                        resp_status_next = ST_BAD_STATE;
                        state_next       = S_RESP;
                    end else begin
                        state_next = S_REL_EVAL;
                    end
                end else if (!desc_ok) begin
                    resp_status_next = ST_UNSUPPORTED;
                    state_next       = S_RESP;
                end else if (req_owner_reg == '0) begin
                    resp_status_next = ST_BAD_STATE;
                    state_next       = S_RESP;
                end else if (cfg_reg.owner_quota == '0) begin
                    resp_status_next = ST_LIMIT;
                    state_next       = S_RESP;
                end else if (active_head_reg >= LINK_NONE) begin
                    state_next = S_FREE;
                end else begin
                    rd_addr    = active_head_reg[AW-1:0];
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                // one active-list entry per cycle, next address straight from the ram
                count_next = count_new;
                steps_next = steps_new;
                if (count_new >= cfg_reg.owner_quota) begin
                    resp_status_next = ST_LIMIT;
                    state_next       = S_RESP;
                end else if (next_rd >= LINK_NONE || steps_new == LW'(SLOTS)) begin
                    state_next = S_FREE;
                end else begin
                    rd_addr = next_rd[AW-1:0];
                end
            end
            S_FREE: begin
                rd_addr       = free_head_reg[AW-1:0];
                work_idx_next = free_head_reg[AW-1:0];
                if (free_head_reg >= LINK_NONE) begin
                    resp_status_next = ST_LIMIT;
                    state_next       = S_RESP;
                end else begin
                    state_next = S_ALLOC_WR1;
                end
            end
            S_ALLOC_WR1: begin
                free_head_next = next_rd;
                next_we     = 1'b1;
                next_wdata  = active_head_reg;
                prev_we     = 1'b1;
                prev_wdata  = LINK_NONE;
                owner_we    = 1'b1;
                owner_wdata = req_owner_reg;
                used_we     = 1'b1;
                used_wdata  = 1'b1;
                state_next  = S_ALLOC_WR2;
            end
            S_ALLOC_WR2: begin
                if (active_head_reg < LINK_NONE) begin
                    prev_we    = 1'b1;
                    prev_waddr = active_head_reg[AW-1:0];
                    prev_wdata = LW'(work_idx_reg);
                end
                active_head_next = LW'(work_idx_reg);
                resp_status_next = ST_OK;
                resp_slot_next   = work_slot4;
                state_next       = S_RESP;
            end
            S_REL_EVAL: begin
                if (!used_rd) begin
                    resp_status_next = ST_BAD_STATE;
                    state_next       = S_RESP;
                end else begin
                    // unlink from the active list
                    if (prev_rd < LINK_NONE) begin
                        next_we    = 1'b1;
                        next_waddr = prev_rd[AW-1:0];
                        next_wdata = next_rd;
                    end else begin
                        active_head_next = next_rd;
                    end
                    if (next_rd < LINK_NONE) begin
                        prev_we    = 1'b1;
                        prev_waddr = next_rd[AW-1:0];
                        prev_wdata = prev_rd;
                    end
                    owner_we    = 1'b1;
                    owner_wdata = '0;
                    used_we     = 1'b1;
                    used_wdata  = 1'b0;
                    state_next  = S_REL_WR2;
                end
            end
            S_REL_WR2: begin
                next_we          = 1'b1;
                next_wdata       = free_head_reg;
                prev_we          = 1'b1;
                prev_wdata       = LINK_NONE;
                free_head_next   = LW'(work_idx_reg);
                resp_status_next = ST_OK;
                state_next       = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            free_head_reg   <= '0;
            active_head_reg <= LINK_NONE;
            clr_idx_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
            cfg_reg.owner_quota  <= QUOTA_W'(16);
            cfg_reg.width_limit  <= '1;
            cfg_reg.height_limit <= '1;
            cfg_reg.buffers_min  <= BUF_W'(2);
            cfg_reg.buffers_max  <= '1;
            cfg_reg.flag_mask    <= '1;
        end else begin
            state_reg       <= state_next;
            free_head_reg   <= free_head_next;
            active_head_reg <= active_head_next;
            clr_idx_reg     <= clr_idx_next;
            if (state_reg == S_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_OWNER_QUOTA:  cfg_reg.owner_quota  <= cfg_data[QUOTA_W-1:0];
                    CFG_WIDTH_LIMIT:  cfg_reg.width_limit  <= cfg_data[DIM_W-1:0];
                    CFG_HEIGHT_LIMIT: cfg_reg.height_limit <= cfg_data[DIM_W-1:0];
                    CFG_BUFFERS_MIN:  cfg_reg.buffers_min  <= cfg_data[BUF_W-1:0];
                    CFG_BUFFERS_MAX:  cfg_reg.buffers_max  <= cfg_data[BUF_W-1:0];
                    CFG_FLAG_MASK:    cfg_reg.flag_mask    <= cfg_data[FLAG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        steps_reg       <= steps_next;
        count_reg       <= count_next;
        work_idx_reg    <= work_idx_next;
        resp_status_reg <= resp_status_next;
        resp_slot_reg   <= resp_slot_next;
        if (s_tvalid && s_tready) begin
            req_type_reg   <= s_tuser[0];
            req_owner_reg  <= s_tdata[15:0];
            req_width_reg  <= s_tdata[31:16];
            req_height_reg <= s_tdata[47:32];
            req_buf_reg    <= s_tdata[55:48];
            req_flags_reg  <= s_tdata[63:56];
            req_rsv_reg    <= s_tdata[79:64];
            req_slot_reg   <= s_tdata[83:80];
        end
        if (state_reg == S_RESP && out_free) begin
            out_status_reg <= resp_status_reg;
            out_slot_reg   <= resp_slot_reg;
        end
    end

`ifndef SYNTH
    // the free and active heads never name the same slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg < LINK_NONE) |-> (free_head_reg != active_head_reg))
        else $error("free and active list share a head slot");

    // a pop always finds a slot on the free list
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC_WR1) |-> $past(free_head_reg < LINK_NONE))
        else $error("allocate popped an empty free list");

    // a transfer in starts a request, no second transfer next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a transfer while busy");
`endif

endmodule

/* rtl/csa_ram.sv */
// csa_ram: generic single write port, single read port ram, registered read
// no dependencies
module csa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/csa_desc_check.sv */
// csa_desc_check: checks an allocate descriptor against the limit registers
// depends on csa_pkg
module csa_desc_check
    import csa_pkg::*;
(
    input  cfg_t              cfg,
    input  logic [DIM_W-1:0]  width,
    input  logic [DIM_W-1:0]  height,
    input  logic [BUF_W-1:0]  buf_cnt,
    input  logic [FLAG_W-1:0] flags,
    input  logic [RSV_W-1:0]  reserved_bytes,
    output logic              desc_ok
);

    logic dims_ok;
    logic bufs_ok;
    logic flags_ok;

    assign dims_ok  = (reserved_bytes == '0)
                   && (width != '0) && (width <= cfg.width_limit)
                   && (height != '0) && (height <= cfg.height_limit);
    // min above max rejects everything
    assign bufs_ok  = (buf_cnt >= cfg.buffers_min) && (buf_cnt <= cfg.buffers_max);
    assign flags_ok = ((flags & ~cfg.flag_mask) == '0);
    assign desc_ok  = dims_ok && bufs_ok && flags_ok;

endmodule
